@@ hdl/bilinear_remap_frame_engine_defines.svh @@
// Assertion macros shared by the frame engine modules.
`ifndef BILINEAR_REMAP_FRAME_ENGINE_DEFINES_SVH
`define BILINEAR_REMAP_FRAME_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bre_pkg.sv @@
package bre_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int X_W        = 9;
    localparam int Y_W        = 8;
    localparam int DEST_W     = 17;
    localparam int FW_W       = 10;
    localparam int FH_W       = 9;
    localparam int CFG_DATA_W = 10;
    localparam int SUM_W      = 18;
    localparam int PROD_W     = 2 * PIX_W;

    // Stream payload layout
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;
    localparam int OFF_X     = 0;
    localparam int OFF_Y     = OFF_X + X_W;
    localparam int OFF_WTL   = OFF_Y + Y_W;
    localparam int OFF_WTR   = OFF_WTL + PIX_W;
    localparam int OFF_WBL   = OFF_WTR + PIX_W;
    localparam int OFF_WBR   = OFF_WBL + PIX_W;
    localparam int OFF_WV    = OFF_WBR + PIX_W;
    localparam int M_USED_W  = PIX_W + DEST_W;

    // Request kinds
    localparam logic OP_WRITE = 1'b1;

    // Register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 10'd512;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 9'd256;

    // Neighbor codes
    localparam logic [1:0] NBR_TL = 2'd0;
    localparam logic [1:0] NBR_TR = 2'd1;
    localparam logic [1:0] NBR_BL = 2'd2;
    localparam logic [1:0] NBR_BR = 2'd3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_WRITE,
        ST_READ,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic       load_item;
        logic       clear_en;
        logic       calc_addr;
        logic       write_src;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       acc_clear;
        logic       mac_en;
        logic [1:0] mac_sel;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_write;
        logic out_free;
    } status_t;

endpackage

@@ hdl/bre_ctrl.sv @@
`include "bilinear_remap_frame_engine_defines.svh"

module bre_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  bre_pkg::status_t status,
    output bre_pkg::cmd_t    cmd
);
    import bre_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] rd_cnt_reg, rd_cnt_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            rd_cnt_reg <= NBR_TL;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.calc_addr = 1'b1;
                cmd.acc_clear = 1'b1;
                rd_cnt_next   = NBR_TL;
                state_next    = status.is_write ? ST_WRITE : ST_READ;
            end
            ST_WRITE: begin
                cmd.write_src = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_READ: begin
                // issue one neighbor read, fold in the previous one
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = rd_cnt_reg;
                if (rd_cnt_reg != NBR_TL) begin
                    cmd.mac_en  = 1'b1;
                    cmd.mac_sel = rd_cnt_reg - 2'd1;
                end
                if (rd_cnt_reg == NBR_BR) begin
                    state_next = ST_FIN;
                end else begin
                    rd_cnt_next = rd_cnt_reg + 2'd1;
                end
            end
            ST_FIN: begin
                // hold until the output register can take the result
                cmd.mac_sel = NBR_BR;
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    `BRE_ASSERT_IMPLY(a_no_accept_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_tready, "request taken during clear pass")
    `BRE_ASSERT_NEXT(a_read_to_fin, aclk, aresetn, (state_reg == ST_READ) && (rd_cnt_reg == NBR_BR), state_reg == ST_FIN, "fourth read did not lead to blend")
    `BRE_ASSERT_NEXT(a_fin_to_idle, aclk, aresetn, (state_reg == ST_FIN) && status.out_free, state_reg == ST_IDLE, "committed result did not return to idle")

endmodule

@@ hdl/bre_datapath.sv @@
`include "bilinear_remap_frame_engine_defines.svh"

module bre_datapath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [bre_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bre_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_index,
    input  logic [bre_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  bre_pkg::cmd_t                         cmd,
    output bre_pkg::status_t                      status
);
    import bre_pkg::*;

    localparam int DEPTH  = (MAX_WIDTH + 1) * (MAX_HEIGHT + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int LAST_W = EW_W + EH_W;

    // Configuration and frame state
    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [DEST_W-1:0] dest_counter_reg, dest_counter_next;
    logic              source_is_b_reg;
    logic [ADDR_W-1:0] clear_cnt_reg;

    // Latched request
    logic              item_op_reg;
    logic [X_W-1:0]    item_x_reg;
    logic [Y_W-1:0]    item_y_reg;
    logic [PIX_W-1:0]  wtl_reg, wtr_reg, wbl_reg, wbr_reg, wv_reg;

    // Address and blend
    logic [EW_W-1:0]   eff_w, x_clamp;
    logic [EH_W-1:0]   eff_h, y_clamp;
    logic [ADDR_W-1:0] base_reg, rd_addr, rd_offset;
    logic [LAST_W-1:0] last_reg;
    logic [PIX_W-1:0]  rd_a_reg, rd_b_reg, pix, weight;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  acc_reg, sum;
    logic [PIX_W-1:0]  color;
    logic              done, dest_in_range;

    // Frame stores and their write ports
    logic [PIX_W-1:0]  store_a [DEPTH];
    logic [PIX_W-1:0]  store_b [DEPTH];
    logic              wr_a_en, wr_b_en;
    logic [ADDR_W-1:0] wr_a_addr, wr_b_addr;
    logic [PIX_W-1:0]  wr_a_data, wr_b_data;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 out_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate frame size to the supported range
    always_comb begin
        if (frame_width_reg < FW_W'(2)) begin
            eff_w = EW_W'(2);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(frame_width_reg);
        end
        if (frame_height_reg < FH_W'(2)) begin
            eff_h = EH_W'(2);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            eff_h = EH_W'(MAX_HEIGHT);
        end else begin
            eff_h = EH_W'(frame_height_reg);
        end
    end

    // Clamp the request position into the frame
    always_comb begin
        if (32'(item_x_reg) >= 32'(eff_w)) begin
            x_clamp = eff_w - EW_W'(1);
        end else begin
            x_clamp = EW_W'(item_x_reg);
        end
        if (32'(item_y_reg) >= 32'(eff_h)) begin
            y_clamp = eff_h - EH_W'(1);
        end else begin
            y_clamp = EH_W'(item_y_reg);
        end
    end

    // Latch the request
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_op_reg <= s_tuser;
            item_x_reg  <= s_tdata[OFF_X +: X_W];
            item_y_reg  <= s_tdata[OFF_Y +: Y_W];
            wtl_reg     <= s_tdata[OFF_WTL +: PIX_W];
            wtr_reg     <= s_tdata[OFF_WTR +: PIX_W];
            wbl_reg     <= s_tdata[OFF_WBL +: PIX_W];
            wbr_reg     <= s_tdata[OFF_WBR +: PIX_W];
            wv_reg      <= s_tdata[OFF_WV +: PIX_W];
        end
    end

    // Form the top-left address and the last raster index
    always_ff @(posedge aclk) begin
        if (cmd.calc_addr) begin
            base_reg <= ADDR_W'(y_clamp * eff_w) + ADDR_W'(x_clamp);
            last_reg <= LAST_W'(eff_w * eff_h) - LAST_W'(1);
        end
    end

    // Neighbor address
    always_comb begin
        unique case (cmd.rd_sel)
            NBR_TL: rd_offset = '0;
            NBR_TR: rd_offset = ADDR_W'(1);
            NBR_BL: rd_offset = ADDR_W'(eff_w);
            NBR_BR: rd_offset = ADDR_W'(eff_w) + ADDR_W'(1);
        endcase
        rd_addr = base_reg + rd_offset;
    end

    // Blend: weight the pixel that came back and add it in
    always_comb begin
        unique case (cmd.mac_sel)
            NBR_TL: weight = wtl_reg;
            NBR_TR: weight = wtr_reg;
            NBR_BL: weight = wbl_reg;
            NBR_BR: weight = wbr_reg;
        endcase
        pix  = source_is_b_reg ? rd_b_reg : rd_a_reg;
        prod = pix * weight;
        sum  = acc_reg + SUM_W'(prod);
        if (sum[SUM_W-1:PIX_W] > (SUM_W - PIX_W)'(PIX_MAX)) begin
            color = PIX_MAX;
        end else begin
            color = sum[PIX_W +: PIX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (cmd.mac_en) begin
            acc_reg <= sum;
        end
    end

    // Frame bookkeeping
    always_comb begin
        done              = 32'(dest_counter_reg) >= 32'(last_reg);
        dest_in_range     = 32'(dest_counter_reg) < 32'(DEPTH);
        dest_counter_next = done ? '0 : dest_counter_reg + DEST_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_counter_reg <= '0;
            source_is_b_reg  <= 1'b0;
        end else if (cmd.commit) begin
            dest_counter_reg <= dest_counter_next;
            if (done) begin
                source_is_b_reg <= !source_is_b_reg;
            end
        end
    end

    // Clear pass over both stores after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
        end else if (cmd.clear_en && !status.clear_done) begin
            clear_cnt_reg <= clear_cnt_reg + ADDR_W'(1);
        end
    end

    // Steer the store write ports
    always_comb begin
        wr_a_en   = 1'b0;
        wr_b_en   = 1'b0;
        wr_a_addr = clear_cnt_reg;
        wr_b_addr = clear_cnt_reg;
        wr_a_data = '0;
        wr_b_data = '0;
        priority if (cmd.clear_en) begin
            wr_a_en = 1'b1;
            wr_b_en = 1'b1;
        end else if (cmd.write_src) begin
            wr_a_en   = !source_is_b_reg;
            wr_b_en   = source_is_b_reg;
            wr_a_addr = base_reg;
            wr_b_addr = base_reg;
            wr_a_data = wv_reg;
            wr_b_data = wv_reg;
        end else if (cmd.commit && dest_in_range) begin
            wr_a_en   = source_is_b_reg;
            wr_b_en   = !source_is_b_reg;
            wr_a_addr = ADDR_W'(dest_counter_reg);
            wr_b_addr = ADDR_W'(dest_counter_reg);
            wr_a_data = color;
            wr_b_data = color;
        end else begin
            wr_a_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_a_en) begin
            store_a[wr_a_addr] <= wr_a_data;
        end
        if (cmd.rd_en) begin
            rd_a_reg <= store_a[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_b_en) begin
            store_b[wr_b_addr] <= wr_b_data;
        end
        if (cmd.rd_en) begin
            rd_b_reg <= store_b[rd_addr];
        end
    end

    // Output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {(M_TDATA_W - M_USED_W)'(0), dest_counter_reg, color};
            m_tlast_reg <= done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Status to the controller
    assign status.clear_done = clear_cnt_reg == ADDR_W'(DEPTH - 1);
    assign status.is_write   = item_op_reg == OP_WRITE;
    assign status.out_free   = out_free;

    `BRE_ASSERT_IMPLY(a_commit_needs_room, aclk, aresetn, cmd.commit, !m_tvalid_reg || m_tready, "result committed over a waiting result")
    `BRE_ASSERT_NEXT(a_frame_end_counter, aclk, aresetn, cmd.commit && done, dest_counter_reg == '0, "raster counter not restarted at frame end")
    `BRE_ASSERT_NEXT(a_frame_end_swap, aclk, aresetn, cmd.commit && done, source_is_b_reg != $past(source_is_b_reg), "stores did not swap at frame end")

endmodule

@@ hdl/bilinear_remap_frame_engine.sv @@
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata, s_tuser (request kind)
// m_        out  m_tvalid/m_tready   m_tdata, m_tlast (last pixel of frame)
// cfg_      in   cfg_wr_en           cfg_index, cfg_wdata (no handshake, no read-back)
//
// A remap request goes through accept, address multiply, four neighbor reads through the
// read port of each frame store, then blend and commit, before the next acceptance.
// A write request steps through accept, address multiply and store write.
// After reset both stores are cleared one entry a cycle over all (MAX_WIDTH+1)*(MAX_HEIGHT+1)
// entries (131841 at the defaults); s_tready stays low until the pass ends.
// The blend stage waits while the output register still holds an untaken result.
module bilinear_remap_frame_engine #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // src_x[8:0], src_y[16:9], weight_top_left[24:17], weight_top_right[32:25],
    // weight_bottom_left[40:33], weight_bottom_right[48:41], write_value[56:49]
    input  logic [bre_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_value[7:0], dest_index[24:8]
    output logic [bre_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [bre_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bre_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence the request
    bre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores, blend and output register
    bre_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
